### design/huffman_table_encoder_top_assert.svh
// Assertion macros for the Huffman table encoder.
`ifndef HUFFMAN_TABLE_ENCODER_TOP_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define HTE_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hte: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define HTE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hte: next-cycle check failed");

`endif

### design/hte_pkg.sv
// Shared types and constants of the Huffman table encoder.
package hte_pkg;

  localparam int unsigned ALPHABET_DEF     = 256;
  localparam int unsigned COUNT_WIDTH_DEF  = 24;
  localparam int unsigned MAX_CODE_LEN_DEF = 40;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned SYMBOL_W    = 8;
  localparam int unsigned CODE_BITS_W = 40;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT  = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_ENCODE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NO_CODES = 2'd2
  } status_e;

endpackage

### design/hte_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module hte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### design/huffman_table_encoder_top.sv
// Huffman table encoder: byte counting, tree build and code lookup over RAMs, plus a clear.
// Count, encode and clear words: a count or encode word reads its table through the RAM's
// read register, then the result is loaded into the output register; the input stays
// closed until that load, and a stalled output register holds it closed until it frees up.
// A build loads the leaves from the count RAM, merges the two lowest active nodes of the
// node RAM until one is left, then walks each counted leaf up to the root for its code.
// Reset (async, active low) clears the count valid bits, total and the ready flag.
module huffman_table_encoder_top #(
  parameter int unsigned ALPHABET     = hte_pkg::ALPHABET_DEF,
  parameter int unsigned COUNT_WIDTH  = hte_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hte_pkg::MODE_W-1:0]       mode_i,
  input  logic [hte_pkg::SYMBOL_W-1:0]     symbol_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [hte_pkg::CODE_BITS_W-1:0]  code_bits_o,
  output logic [hte_pkg::LEN_W-1:0]        code_length_o,
  output logic [hte_pkg::STATUS_W-1:0]     status_o
);

  localparam int unsigned NODES      = 2 * ALPHABET - 1;
  localparam int unsigned NODE_W     = $clog2(NODES);
  localparam int unsigned SYM_W      = $clog2(ALPHABET);
  localparam int unsigned LIVE_W     = $clog2(ALPHABET + 1);
  localparam int unsigned CODE_LIMIT = (MAX_CODE_LEN < hte_pkg::CODE_BITS_W) ?
                                       MAX_CODE_LEN : hte_pkg::CODE_BITS_W;
  localparam int unsigned ENTRY_W    = hte_pkg::LEN_W + CODE_LIMIT;
  localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = '1;
  localparam logic [hte_pkg::SYMBOL_W:0] SYM_LIMIT = (hte_pkg::SYMBOL_W + 1)'(ALPHABET);
  localparam logic [NODE_W-1:0] LEAF_END  = NODE_W'(ALPHABET);
  localparam logic [NODE_W-1:0] LEAF_LAST = NODE_W'(ALPHABET - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ITEM, S_INIT, S_SCAN, S_MRG_A, S_MRG_B, S_MRG_N,
    S_WALK_LEAF, S_WALK_CHK, S_WALK_STEP, S_WALK_UP, S_OUT
  } state_e;

  state_e                      state_q;
  hte_pkg::mode_e              mode_q;
  logic [SYM_W-1:0]            sym_q;
  logic                        sym_ok_q;
  logic [COUNT_WIDTH-1:0]      total_q;
  logic                        codes_ready_q;
  logic [ALPHABET-1:0]         cnt_vld_q;
  logic                        cnt_rvld_q;
  logic [NODE_W-1:0]           next_q;
  logic [LIVE_W-1:0]           live_q;
  logic [NODE_W-1:0]           idx_q;
  logic                        pipe_vld_q;
  logic [NODE_W-1:0]           pipe_idx_q;
  logic                        b1_vld_q, b2_vld_q;
  logic [NODE_W-1:0]           b1_idx_q, b2_idx_q;
  logic [COUNT_WIDTH-1:0]      b1_w_q, b2_w_q;
  logic [NODE_W-1:0]           node_q;
  logic [NODE_W-1:0]           len_q;
  logic [CODE_LIMIT-1:0]       code_q;
  logic [hte_pkg::CODE_BITS_W-1:0] res_bits_q;
  logic [hte_pkg::LEN_W-1:0]   res_len_q;
  hte_pkg::status_e            res_st_q;
  logic                        out_valid_q;
  logic [hte_pkg::CODE_BITS_W-1:0] out_bits_q;
  logic [hte_pkg::LEN_W-1:0]   out_len_q;
  hte_pkg::status_e            out_st_q;

  // RAM ports
  logic                        cnt_we, cnt_re;
  logic [SYM_W-1:0]            cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0]      cnt_wdata, cnt_rdata;
  logic                        wa_we, wa_re;
  logic [NODE_W-1:0]           wa_waddr;
  logic [COUNT_WIDTH:0]        wa_wdata, wa_rdata;
  logic                        pb_we, pb_re;
  logic [NODE_W-1:0]           pb_waddr;
  logic [NODE_W:0]             pb_wdata, pb_rdata;
  logic                        code_we, code_re;
  logic [SYM_W-1:0]            code_waddr;
  logic [ENTRY_W-1:0]          code_wdata, code_rdata;

  logic                        in_accept;
  logic                        out_free;
  logic                        out_load;
  logic [COUNT_WIDTH-1:0]      cur_cnt;
  logic                        cur_nz;
  logic [NODE_W-1:0]           root;
  logic                        len_fits;
  logic [COUNT_WIDTH-1:0]      scan_w;
  logic                        scan_act;
  logic [LIVE_W-1:0]           live_next;
  logic [hte_pkg::CODE_BITS_W-1:0] item_bits;
  logic [hte_pkg::LEN_W-1:0]   item_len;
  hte_pkg::status_e            item_st;
  logic                        count_ovf;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = out_free && ((state_q == S_ITEM) || (state_q == S_OUT));
  assign cur_cnt    = cnt_rvld_q ? cnt_rdata : '0;
  assign cur_nz     = (cur_cnt != '0);
  assign root       = next_q - NODE_W'(1);
  assign len_fits   = ({{(32 - NODE_W){1'b0}}, len_q} <= 32'(CODE_LIMIT));
  assign scan_w     = wa_rdata[COUNT_WIDTH-1:0];
  assign scan_act   = wa_rdata[COUNT_WIDTH];
  assign live_next  = live_q + LIVE_W'(cur_nz);
  assign count_ovf  = (total_q == COUNT_LIMIT);

  // Result of a count or encode word, from the table read of the previous cycle.
  always_comb begin
    item_bits = '0;
    item_len  = '0;
    item_st   = hte_pkg::ST_OK;
    if (mode_q == hte_pkg::MODE_COUNT) begin
      if (count_ovf) begin
        item_st = hte_pkg::ST_OVERFLOW;
      end
    end else if (!codes_ready_q) begin
      item_st = hte_pkg::ST_NO_CODES;
    end else if (sym_ok_q) begin
      item_bits = hte_pkg::CODE_BITS_W'(code_rdata[CODE_LIMIT-1:0]);
      item_len  = code_rdata[ENTRY_W-1 -: hte_pkg::LEN_W];
    end
  end

  // Steer the RAM ports from the sequencer state.
  always_comb begin
    cnt_re     = 1'b0;
    cnt_raddr  = idx_q[SYM_W-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = sym_q;
    cnt_wdata  = cur_cnt + COUNT_WIDTH'(1);
    wa_re      = 1'b0;
    wa_we      = 1'b0;
    wa_waddr   = pipe_idx_q;
    wa_wdata   = {cur_nz, cur_cnt};
    pb_re      = 1'b0;
    pb_we      = 1'b0;
    pb_waddr   = b1_idx_q;
    pb_wdata   = {next_q, 1'b0};
    code_re    = 1'b0;
    code_we    = 1'b0;
    code_waddr = idx_q[SYM_W-1:0];
    code_wdata = '0;
    unique case (state_q)
      S_IDLE: begin
        cnt_re    = in_accept;
        cnt_raddr = symbol_i[SYM_W-1:0];
        code_re   = in_accept;
      end
      S_ITEM: begin
        cnt_we = (mode_q == hte_pkg::MODE_COUNT) && !count_ovf && sym_ok_q;
      end
      S_INIT: begin
        cnt_re = (idx_q < LEAF_END);
        wa_we  = pipe_vld_q;
      end
      S_SCAN: begin
        wa_re = (idx_q < next_q);
      end
      S_MRG_A: begin
        wa_we    = 1'b1;
        wa_waddr = b1_idx_q;
        wa_wdata = {1'b0, b1_w_q};
        pb_we    = 1'b1;
      end
      S_MRG_B: begin
        wa_we    = 1'b1;
        wa_waddr = b2_idx_q;
        wa_wdata = {1'b0, b2_w_q};
        pb_we    = 1'b1;
        pb_waddr = b2_idx_q;
        pb_wdata = {next_q, 1'b1};
      end
      S_MRG_N: begin
        wa_we    = 1'b1;
        wa_waddr = next_q;
        wa_wdata = {1'b1, b1_w_q + b2_w_q};
      end
      S_WALK_LEAF: begin
        cnt_re = 1'b1;
      end
      S_WALK_CHK: begin
        code_we = !cur_nz || (next_q == LEAF_END);
      end
      S_WALK_STEP: begin
        if (node_q == root) begin
          code_we    = 1'b1;
          code_wdata = len_fits ? {hte_pkg::LEN_W'(len_q), code_q} : '0;
        end else begin
          pb_re = 1'b1;
        end
      end
      S_WALK_UP, S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  hte_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET), .AW(SYM_W)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .re_i(cnt_re), .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  hte_ram #(.WIDTH(COUNT_WIDTH + 1), .DEPTH(NODES), .AW(NODE_W)) u_wa_ram (
    .clk_i, .we_i(wa_we), .waddr_i(wa_waddr), .wdata_i(wa_wdata),
    .re_i(wa_re), .raddr_i(idx_q), .rdata_o(wa_rdata)
  );

  hte_ram #(.WIDTH(NODE_W + 1), .DEPTH(NODES), .AW(NODE_W)) u_pb_ram (
    .clk_i, .we_i(pb_we), .waddr_i(pb_waddr), .wdata_i(pb_wdata),
    .re_i(pb_re), .raddr_i(node_q), .rdata_o(pb_rdata)
  );

  hte_ram #(.WIDTH(ENTRY_W), .DEPTH(ALPHABET), .AW(SYM_W)) u_code_ram (
    .clk_i, .we_i(code_we), .waddr_i(code_waddr), .wdata_i(code_wdata),
    .re_i(code_re), .raddr_i(symbol_i[SYM_W-1:0]), .rdata_o(code_rdata)
  );

  // Sequencer: state, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      total_q       <= '0;
      codes_ready_q <= 1'b0;
      cnt_vld_q     <= '0;
      pipe_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      // Raise the output word on a load, drop it once taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cnt_re) begin
        cnt_rvld_q <= cnt_vld_q[cnt_raddr];
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            mode_q   <= hte_pkg::mode_e'(mode_i);
            sym_q    <= symbol_i[SYM_W-1:0];
            sym_ok_q <= ({1'b0, symbol_i} < SYM_LIMIT);
            res_bits_q <= '0;
            res_len_q  <= '0;
            res_st_q   <= hte_pkg::ST_OK;
            unique case (hte_pkg::mode_e'(mode_i))
              hte_pkg::MODE_BUILD: begin
                next_q     <= LEAF_END;
                live_q     <= '0;
                idx_q      <= '0;
                pipe_vld_q <= 1'b0;
                state_q    <= S_INIT;
              end
              hte_pkg::MODE_CLEAR: begin
                cnt_vld_q     <= '0;
                total_q       <= '0;
                codes_ready_q <= 1'b0;
                state_q       <= S_OUT;
              end
              default: begin
                state_q <= S_ITEM;
              end
            endcase
          end
        end
        S_ITEM: begin
          if (cnt_we) begin
            total_q          <= total_q + COUNT_WIDTH'(1);
            cnt_vld_q[sym_q] <= 1'b1;
            codes_ready_q    <= 1'b0;
          end
          res_bits_q <= item_bits;
          res_len_q  <= item_len;
          res_st_q   <= item_st;
          if (out_free) begin
            out_bits_q  <= item_bits;
            out_len_q   <= item_len;
            out_st_q    <= item_st;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_INIT: begin
          // Copy counts into the leaf entries and count live leaves.
          pipe_vld_q <= (idx_q < LEAF_END);
          pipe_idx_q <= idx_q;
          if (idx_q < LEAF_END) begin
            idx_q <= idx_q + NODE_W'(1);
          end
          if (pipe_vld_q) begin
            live_q <= live_next;
            if (pipe_idx_q == LEAF_LAST) begin
              idx_q      <= '0;
              b1_vld_q   <= 1'b0;
              b2_vld_q   <= 1'b0;
              state_q    <= (live_next > LIVE_W'(1)) ? S_SCAN : S_WALK_LEAF;
            end
          end
        end
        S_SCAN: begin
          // Track the two lowest active nodes; ascending order breaks ties.
          pipe_vld_q <= wa_re;
          pipe_idx_q <= idx_q;
          if (wa_re) begin
            idx_q <= idx_q + NODE_W'(1);
          end
          if (pipe_vld_q && scan_act) begin
            if (!b1_vld_q || scan_w < b1_w_q) begin
              b1_vld_q <= 1'b1;
              b1_idx_q <= pipe_idx_q;
              b1_w_q   <= scan_w;
              b2_vld_q <= b1_vld_q;
              b2_idx_q <= b1_idx_q;
              b2_w_q   <= b1_w_q;
            end else if (!b2_vld_q || scan_w < b2_w_q) begin
              b2_vld_q <= 1'b1;
              b2_idx_q <= pipe_idx_q;
              b2_w_q   <= scan_w;
            end
          end
          if (!pipe_vld_q && !wa_re) begin
            state_q <= S_MRG_A;
          end
        end
        S_MRG_A: begin
          state_q <= S_MRG_B;
        end
        S_MRG_B: begin
          state_q <= S_MRG_N;
        end
        S_MRG_N: begin
          next_q     <= next_q + NODE_W'(1);
          live_q     <= live_q - LIVE_W'(1);
          idx_q      <= '0;
          pipe_vld_q <= 1'b0;
          b1_vld_q   <= 1'b0;
          b2_vld_q   <= 1'b0;
          state_q    <= (live_q > LIVE_W'(2)) ? S_SCAN : S_WALK_LEAF;
        end
        S_WALK_LEAF: begin
          node_q  <= idx_q;
          len_q   <= '0;
          code_q  <= '0;
          state_q <= S_WALK_CHK;
        end
        S_WALK_CHK, S_WALK_STEP: begin
          if (code_we) begin
            // Advance to the next leaf, or finish the build.
            if (idx_q == LEAF_LAST) begin
              codes_ready_q <= 1'b1;
              state_q       <= S_OUT;
            end else begin
              idx_q   <= idx_q + NODE_W'(1);
              state_q <= S_WALK_LEAF;
            end
          end else begin
            state_q <= (state_q == S_WALK_CHK) ? S_WALK_STEP : S_WALK_UP;
          end
        end
        S_WALK_UP: begin
          node_q  <= pb_rdata[NODE_W:1];
          code_q  <= code_q | ({{(CODE_LIMIT - 1){1'b0}}, pb_rdata[0]} << len_q);
          len_q   <= len_q + NODE_W'(1);
          state_q <= S_WALK_STEP;
        end
        S_OUT: begin
          // Hold the finished word until the output register is free.
          if (out_free) begin
            out_bits_q  <= res_bits_q;
            out_len_q   <= res_len_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_bits_o   = out_bits_q;
  assign code_length_o = out_len_q;
  assign status_o      = out_st_q;

`include "huffman_table_encoder_top_assert.svh"

  // An accepted word closes the input in the next cycle.
  `HTE_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)
  // An error status never carries a code.
  `HTE_ASSERT_IMPL(a_err_no_code, out_valid_o && (status_o != hte_pkg::ST_OK), code_length_o == '0)
  // A merge scan runs only with at least two live nodes.
  `HTE_ASSERT_IMPL(a_scan_live, state_q == S_SCAN, live_q > LIVE_W'(1))
  // A stored code never exceeds the code limit.
  `HTE_ASSERT_IMPL(a_len_cap, out_valid_o, 32'(code_length_o) <= 32'(CODE_LIMIT))

endmodule

### bench/huffman_table_encoder_checker.sv
// Checker for the Huffman table encoder: predicts each result word and compares.
module huffman_table_encoder_checker
  import hte_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [SYMBOL_W-1:0]    symbol_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [CODE_BITS_W-1:0] code_bits_i,
  input  logic [LEN_W-1:0]       code_length_i,
  input  logic [STATUS_W-1:0]    status_i,
  output int                     errors_o,
  output int                     outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSYM  = ALPHABET_DEF;
  localparam int unsigned NNODE = 2 * NSYM - 1;
  localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;
  localparam int unsigned CODE_MAX =
    (MAX_CODE_LEN_DEF < CODE_BITS_W) ? MAX_CODE_LEN_DEF : CODE_BITS_W;

  typedef struct packed {
    logic [CODE_BITS_W-1:0] code_bits;
    logic [LEN_W-1:0]       code_length;
    status_e                status;
  } code_word_t;

  logic [COUNT_WIDTH_DEF-1:0] freq [NSYM];
  logic [COUNT_WIDTH_DEF-1:0] freq_total;
  logic [COUNT_WIDTH_DEF-1:0] weight [NNODE];
  int unsigned                parent [NNODE];
  logic                       branch [NNODE];
  logic                       live_node [NNODE];
  logic [CODE_BITS_W-1:0]     code_of [NSYM];
  logic [LEN_W-1:0]           len_of [NSYM];
  logic                       codes_valid;
  code_word_t                 pending_codes [$];

  function automatic void clear_model();
    for (int i = 0; i < NSYM; i++) begin
      freq[i] = '0;
      code_of[i] = '0;
      len_of[i] = '0;
    end
    freq_total = '0;
    codes_valid = 1'b0;
  endfunction

  // Pop the lowest active node, lower index on ties.
  function automatic int pop_lightest(int limit);
    int best;
    best = -1;
    for (int i = 0; i < limit; i++)
      if (live_node[i] && (best < 0 || weight[i] < weight[best])) best = i;
    if (best >= 0) live_node[best] = 1'b0;
    return best;
  endfunction

  function automatic void build_tree();
    int nxt, nlive, a, b, node, len;
    logic [63:0] code;
    nxt = NSYM;
    nlive = 0;
    for (int i = 0; i < NNODE; i++) live_node[i] = 1'b0;
    for (int i = 0; i < NSYM; i++) begin
      weight[i] = freq[i];
      if (freq[i] != 0) begin
        live_node[i] = 1'b1;
        nlive++;
      end
    end
    while (nlive > 1 && nxt < NNODE) begin
      a = pop_lightest(nxt);
      b = pop_lightest(nxt);
      weight[nxt] = weight[a] + weight[b];
      parent[a] = nxt;
      branch[a] = 1'b0;
      parent[b] = nxt;
      branch[b] = 1'b1;
      live_node[nxt] = 1'b1;
      nxt++;
      nlive--;
    end
    for (int i = 0; i < NSYM; i++) begin
      code_of[i] = '0;
      len_of[i] = '0;
      if (freq[i] == 0 || nxt == NSYM) continue;
      code = '0;
      len = 0;
      node = i;
      // Walk up to the root; the first branch taken from the leaf is the LSB.
      while (node != nxt - 1 && len <= NNODE) begin
        if (len < 64) code[len] = branch[node];
        len++;
        node = parent[node];
      end
      if (len <= CODE_MAX) begin
        code_of[i] = code[CODE_BITS_W-1:0];
        len_of[i] = len[LEN_W-1:0];
      end
    end
    codes_valid = 1'b1;
  endfunction

  function automatic code_word_t predict_code(mode_e mode, logic [SYMBOL_W-1:0] sym);
    code_word_t w;
    w = '{code_bits: '0, code_length: '0, status: ST_OK};
    case (mode)
      MODE_COUNT: begin
        if (freq_total == COUNT_MAX) w.status = ST_OVERFLOW;
        else begin
          freq[sym]++;
          freq_total++;
          codes_valid = 1'b0;
        end
      end
      MODE_BUILD: build_tree();
      MODE_ENCODE: begin
        if (!codes_valid) w.status = ST_NO_CODES;
        else begin
          w.code_bits = code_of[sym];
          w.code_length = len_of[sym];
        end
      end
      default: clear_model();
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    code_word_t want;
    if (!rst_ni) begin
      clear_model();
      pending_codes.delete();
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_codes.size() == 0) begin
          $error("unexpected result word: code_bits %h code_length %0d status %0d",
                 code_bits_i, code_length_i, status_i);
          errors_o <= errors_o + 1;
        end else begin
          want = pending_codes.pop_front();
          if (code_bits_i !== want.code_bits ||
              code_length_i !== want.code_length ||
              status_i !== want.status) begin
            if (code_bits_i !== want.code_bits)
              $error("code_bits: expected %h, actual %h", want.code_bits, code_bits_i);
            if (code_length_i !== want.code_length)
              $error("code_length: expected %0d, actual %0d",
                     want.code_length, code_length_i);
            if (status_i !== want.status)
              $error("status: expected %0d, actual %0d", want.status, status_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = predict_code(mode_e'(mode_i), symbol_i);
        pending_codes = {pending_codes, want};
      end
      outstanding_o <= pending_codes.size();
    end
  end

endmodule

### bench/tb_huffman_table_encoder_top.sv
// Testbench top for the Huffman table encoder: stimulus, back-pressure and verdict.
module tb_huffman_table_encoder_top;
  import hte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 900;
  // Drop all idling once more than this many words have gone in.
  localparam int CALM_AFTER   = 800;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [MODE_W-1:0]      mode_i = MODE_CLEAR;
  logic [SYMBOL_W-1:0]    symbol_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [CODE_BITS_W-1:0] code_bits_o;
  logic [LEN_W-1:0]       code_length_o;
  logic [STATUS_W-1:0]    status_o;
  int                     errors;
  int                     outstanding;
  int                     words_sent = 0;
  logic                   calm = 1'b0;
  logic                   big_done = 1'b0;

  huffman_table_encoder_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .symbol_i,
    .out_valid_o, .out_ready_i, .code_bits_o, .code_length_o, .status_o
  );

  huffman_table_encoder_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .symbol_i,
    .out_valid_i(out_valid_o), .out_ready_i, .code_bits_i(code_bits_o),
    .code_length_i(code_length_o), .status_i(status_o),
    .errors_o(errors), .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: stall in random bursts, with long stretches of none.
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Present one word at a falling edge and hold it until accepted.
  task automatic send_word(mode_e mode, logic [SYMBOL_W-1:0] sym);
    if (!calm && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= mode;
    symbol_i <= sym;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    calm = (words_sent > CALM_AFTER);
  endtask

  // Hold the sender off until every result word is back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Count a random set of k bytes with skewed weights, build, then encode.
  task automatic run_table(int k, int counts, int encodes);
    logic [SYMBOL_W-1:0] syms [$];
    logic [SYMBOL_W-1:0] s;
    for (int i = 0; i < k; i++) begin
      s = SYMBOL_W'($urandom_range(0, 255));
      syms = {syms, s};
    end
    for (int i = 0; i < counts; i++)
      send_word(MODE_COUNT, syms[$urandom_range(0, $urandom_range(0, k - 1))]);
    send_word(MODE_BUILD, SYMBOL_W'($urandom_range(0, 255)));
    for (int i = 0; i < encodes; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_word(MODE_ENCODE, SYMBOL_W'($urandom_range(0, 255)));
      else send_word(MODE_ENCODE, syms[$urandom_range(0, k - 1)]);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Encode with no table yet, then a small table with extreme bytes and ties.
    send_word(MODE_ENCODE, 8'h00);
    send_word(MODE_COUNT, 8'h00);
    send_word(MODE_COUNT, 8'hFF);
    send_word(MODE_COUNT, 8'h55);
    send_word(MODE_COUNT, 8'hAA);
    send_word(MODE_COUNT, 8'h00);
    send_word(MODE_BUILD, 8'h00);
    send_word(MODE_ENCODE, 8'h00);
    send_word(MODE_ENCODE, 8'hFF);
    send_word(MODE_ENCODE, 8'h55);
    send_word(MODE_ENCODE, 8'hAA);
    send_word(MODE_ENCODE, 8'h01);  // never counted
    send_word(MODE_COUNT, 8'h55);   // stale table after this count
    send_word(MODE_ENCODE, 8'h55);
    // One-symbol alphabet gives empty codes.
    send_word(MODE_CLEAR, 8'hFF);
    send_word(MODE_COUNT, 8'h07);
    send_word(MODE_COUNT, 8'h07);
    send_word(MODE_BUILD, 8'h00);
    send_word(MODE_ENCODE, 8'h07);
    // Empty alphabet, then encode straight after a clear.
    send_word(MODE_CLEAR, 8'h00);
    send_word(MODE_BUILD, 8'h00);
    send_word(MODE_ENCODE, 8'h80);
    send_word(MODE_CLEAR, 8'h00);
    send_word(MODE_ENCODE, 8'h80);
    drain_results();

    while (words_sent < RANDOM_WORDS) begin
      if (!big_done && words_sent > 400) begin
        // One full-alphabet table; its build is the slow one.
        big_done = 1'b1;
        send_word(MODE_CLEAR, 8'h00);
        for (int i = 0; i < 256; i++) send_word(MODE_COUNT, i[SYMBOL_W-1:0]);
        for (int i = 0; i < 40; i++)
          send_word(MODE_COUNT, SYMBOL_W'($urandom_range(0, 255)));
        send_word(MODE_BUILD, 8'h00);
        for (int i = 0; i < 30; i++)
          send_word(MODE_ENCODE, SYMBOL_W'($urandom_range(0, 255)));
      end else begin
        run_table($urandom_range(2, ($urandom_range(0, 9) == 0) ? 40 : 10),
                  $urandom_range(4, 30), $urandom_range(4, 14));
      end
      // Noise: any mode, any byte.
      repeat ($urandom_range(0, 3))
        send_word(mode_e'($urandom_range(0, 3)), SYMBOL_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) drain_results();
      if ($urandom_range(0, 1) == 0)
        send_word(MODE_CLEAR, SYMBOL_W'($urandom_range(0, 255)));
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("huffman_table_encoder_top: match");
    end else begin
      $display("huffman_table_encoder_top: mismatch");
    end
    $finish;
  end

  // Watchdog: several times the slowest expected run.
  initial begin
    #100ms;
    $display("huffman_table_encoder_top: mismatch");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/hte_pkg.sv
design/hte_ram.sv
design/huffman_table_encoder_top.sv
bench/huffman_table_encoder_checker.sv
bench/tb_huffman_table_encoder_top.sv
